// ----- rtl/tav_pkg.sv -----
package tav_pkg;

    localparam int MAX_ATTRS   = 8;
    localparam int TABLE_CODES = 8;
    localparam int HDR_BYTES   = 2;

    localparam int CFG_DW = 64;
    localparam int CFG_AW = 3;

    // register indexes
    localparam logic [CFG_AW-1:0] REG_EXP_CODES  = 3'd0;
    localparam logic [CFG_AW-1:0] REG_EXP_COUNT  = 3'd1;
    localparam logic [CFG_AW-1:0] REG_KNOWN_LO   = 3'd2;
    localparam logic [CFG_AW-1:0] REG_KNOWN_HI   = 3'd3;
    localparam logic [CFG_AW-1:0] REG_LEN_TABLE  = 3'd4;
    localparam logic [CFG_AW-1:0] REG_ZTERM_MASK = 3'd5;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_TYPE = 2'd1,
        PH_LEN  = 2'd2,
        PH_DATA = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_HDR_OVR   = 3'd1,
        ERR_BAD_TYPE  = 3'd2,
        ERR_DATA_OVR  = 3'd3,
        ERR_ZERO_LEN  = 3'd4,
        ERR_SIZE      = 3'd5,
        ERR_UNTERM    = 3'd6
    } t_err;

endpackage

// ----- rtl/tav_in_if.sv -----
interface tav_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [15:0] value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

// ----- rtl/tav_res_if.sv -----
interface tav_res_if;
    logic       valid;
    logic       ready;
    logic       ok;
    logic [2:0] error_code;
    logic [2:0] attr_index;

    modport source (output valid, output ok, output error_code, output attr_index, input ready);
    modport sink   (input valid, input ok, input error_code, input attr_index, output ready);
endinterface

// ----- rtl/tlv_attribute_validator.sv -----
// Channel   Dir  Payload                              Beat
// i_in      in   command(1) value(16)                 start or one payload byte
// o_res     out  ok(1) error_code(3) attr_index(3)    one verdict per message
// i_cfg_*   in   we, idx(3), data(64)                 register write, no read-back
//
// One input beat per cycle while i_in.ready is high. Each beat updates the
// parse state and, when a verdict is reached, loads the result register in
// the same cycle; the verdict shows on o_res in the cycle after the
// deciding beat. i_in.ready drops only while a verdict sits in the result
// register and o_res.ready is low. Synchronous active-low reset clears the
// parse state, the result valid and the registers (known_hi resets to 7).
module tlv_attribute_validator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    tav_in_if.sink                      i_in,
    tav_res_if.source                   o_res,
    input  logic                        i_cfg_we,
    input  logic [tav_pkg::CFG_AW-1:0]  i_cfg_idx,
    input  logic [tav_pkg::CFG_DW-1:0]  i_cfg_data
);
    import tav_pkg::*;

    // configuration registers
    logic [63:0] r_exp_codes;
    logic [3:0]  r_exp_count;
    logic [2:0]  r_known_lo;
    logic [2:0]  r_known_hi;
    logic [63:0] r_len_table;
    logic [7:0]  r_zterm_mask;

    // parse state
    t_phase      r_phase,     n_phase;
    logic [15:0] r_bytes,     n_bytes;
    logic [3:0]  r_pos,       n_pos;
    logic [7:0]  r_cur_type,  n_cur_type;
    logic [7:0]  r_data_left, n_data_left;

    // result register
    logic        r_ov,  n_ov;
    logic        r_ok,  n_ok;
    t_err        r_err, n_err;
    logic [2:0]  r_idx, n_idx;

    logic        accept;
    logic [3:0]  eff_cnt;
    logic [7:0]  b;
    logic [15:0] bytes_dec;
    logic [7:0]  exp_code;
    logic [7:0]  need_len;
    logic        known;
    logic        zterm;

    // begin-next-attribute evaluation, shared by start of message and end of attribute
    logic        na_go;
    logic [3:0]  na_pos;
    logic [15:0] na_bytes;

    assign i_in.ready = !r_ov || o_res.ready;
    assign accept     = i_in.valid && i_in.ready;

    assign o_res.valid      = r_ov;
    assign o_res.ok         = r_ok;
    assign o_res.error_code = r_err;
    assign o_res.attr_index = r_idx;

    assign eff_cnt   = (r_exp_count > 4'(MAX_ATTRS)) ? 4'(MAX_ATTRS) : r_exp_count;
    assign b         = i_in.value[7:0];
    assign bytes_dec = (r_bytes != 16'd0) ? r_bytes - 16'd1 : r_bytes;
    assign exp_code  = r_exp_codes[{r_pos[2:0], 3'b000} +: 8];
    assign need_len  = r_len_table[{r_cur_type[2:0], 3'b000} +: 8];
    assign known     = ({5'd0, r_known_lo} <= r_cur_type) && (r_cur_type <= {5'd0, r_known_hi})
                       && (r_cur_type < 8'(TABLE_CODES));
    assign zterm     = r_zterm_mask[r_cur_type[2:0]];

    always_comb begin
        n_phase     = r_phase;
        n_bytes     = r_bytes;
        n_pos       = r_pos;
        n_cur_type  = r_cur_type;
        n_data_left = r_data_left;
        n_ov        = r_ov && !o_res.ready;
        n_ok        = r_ok;
        n_err       = r_err;
        n_idx       = r_idx;
        na_go       = 1'b0;
        na_pos      = 4'd0;
        na_bytes    = i_in.value;

        if (accept) begin
            if (!i_in.command) begin
                // start of message: restart abandons any message in flight
                n_bytes     = i_in.value;
                n_pos       = 4'd0;
                n_cur_type  = 8'd0;
                n_data_left = 8'd0;
                na_go       = 1'b1;
                na_pos      = 4'd0;
                na_bytes    = i_in.value;
            end else if (r_phase != PH_IDLE) begin
                n_bytes = bytes_dec;
                case (r_phase)
                    PH_TYPE: begin
                        n_cur_type = b;
                        if (b != exp_code) begin
                            n_ov = 1'b1; n_ok = 1'b0; n_err = ERR_BAD_TYPE;
                            n_idx = r_pos[2:0]; n_phase = PH_IDLE;
                        end else begin
                            n_phase = PH_LEN;
                        end
                    end
                    PH_LEN: begin
                        if ({8'd0, b} > bytes_dec) begin
                            n_ov = 1'b1; n_ok = 1'b0; n_err = ERR_DATA_OVR;
                            n_idx = r_pos[2:0]; n_phase = PH_IDLE;
                        end else if (b == 8'd0) begin
                            n_ov = 1'b1; n_ok = 1'b0; n_err = ERR_ZERO_LEN;
                            n_idx = r_pos[2:0]; n_phase = PH_IDLE;
                        end else if (known && need_len != 8'd0 && b != need_len) begin
                            n_ov = 1'b1; n_ok = 1'b0; n_err = ERR_SIZE;
                            n_idx = r_pos[2:0]; n_phase = PH_IDLE;
                        end else begin
                            n_data_left = b;
                            n_phase     = PH_DATA;
                        end
                    end
                    PH_DATA: begin
                        n_data_left = (r_data_left != 8'd0) ? r_data_left - 8'd1 : r_data_left;
                        if (n_data_left == 8'd0) begin
                            // last data byte of the attribute is this beat
                            if (known && zterm && b != 8'd0) begin
                                n_ov = 1'b1; n_ok = 1'b0; n_err = ERR_UNTERM;
                                n_idx = r_pos[2:0]; n_phase = PH_IDLE;
                            end else begin
                                n_pos    = r_pos + 4'd1;
                                na_go    = 1'b1;
                                na_pos   = r_pos + 4'd1;
                                na_bytes = bytes_dec;
                            end
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end

            if (na_go) begin
                // live count: lowering it mid-message ends with ok
                if (na_pos >= eff_cnt) begin
                    n_ov = 1'b1; n_ok = 1'b1; n_err = ERR_NONE;
                    n_idx = (eff_cnt == 4'd0) ? 3'd0 : 3'(eff_cnt - 4'd1);
                    n_phase = PH_IDLE;
                end else if (na_bytes < 16'(HDR_BYTES)) begin
                    n_ov = 1'b1; n_ok = 1'b0; n_err = ERR_HDR_OVR;
                    n_idx = na_pos[2:0]; n_phase = PH_IDLE;
                end else begin
                    n_phase = PH_TYPE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_bytes     <= '0;
            r_pos       <= '0;
            r_cur_type  <= '0;
            r_data_left <= '0;
            r_ov        <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_bytes     <= n_bytes;
            r_pos       <= n_pos;
            r_cur_type  <= n_cur_type;
            r_data_left <= n_data_left;
            r_ov        <= n_ov;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_ok  <= n_ok;
        r_err <= n_err;
        r_idx <= n_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_codes  <= '0;
            r_exp_count  <= '0;
            r_known_lo   <= '0;
            r_known_hi   <= 3'd7;
            r_len_table  <= '0;
            r_zterm_mask <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_EXP_CODES:  r_exp_codes  <= i_cfg_data;
                REG_EXP_COUNT:  r_exp_count  <= i_cfg_data[3:0];
                REG_KNOWN_LO:   r_known_lo   <= i_cfg_data[2:0];
                REG_KNOWN_HI:   r_known_hi   <= i_cfg_data[2:0];
                REG_LEN_TABLE:  r_len_table  <= i_cfg_data;
                REG_ZTERM_MASK: r_zterm_mask <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

endmodule
